@@ hw/rtl/cpt_pkg.sv @@
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types, constants and fixed-point helpers for the camera projection
// pipeline.
// ----------------------------------------------------------------------------
package cpt_pkg;

    // Working format: signed 64 bits with 32 fraction bits.
    localparam int WORK_FRAC      = 32;
    localparam int TEX_FRAC       = 16;
    localparam int NUM_COEF       = 23;
    localparam int COEF_W         = 48;
    localparam int CFG_IDX_W      = 2;
    localparam int DIV_STEP       = 2;
    localparam int COORD_FRAC_DEF = 16;
    localparam int COEF_FRAC_DEF  = 32;

    typedef logic signed [63:0] t_fix;

    localparam t_fix FIX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_fix FIX_MIN = 64'sh8000_0000_0000_0000;
    localparam t_fix FIX_ONE = 64'sh0000_0001_0000_0000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_SEL  = 2'd0,
        CFG_COEF_WORD = 2'd1,
        CFG_WIDTH     = 2'd2,
        CFG_HEIGHT    = 2'd3
    } t_cfg_idx;

    // Coefficient word positions.
    localparam int K_ROT = 0;
    localparam int K_TRN = 9;
    localparam int K_K0  = 12;
    localparam int K_K1  = 13;
    localparam int K_K2  = 14;
    localparam int K_K3  = 15;
    localparam int K_K4  = 16;
    localparam int K_F   = 17;
    localparam int K_SX  = 18;
    localparam int K_XC  = 19;
    localparam int K_YC  = 20;
    localparam int K_DX  = 21;
    localparam int K_DY  = 22;

    // Magnitude of a signed word; the most negative value maps to 2^63.
    function automatic logic [63:0] mag64(input t_fix v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Apply a sign to a magnitude below 2^63, or saturate on overflow.
    function automatic t_fix sat_pack(input logic neg, input logic ovf,
                                      input logic [62:0] m);
        if (ovf) return neg ? FIX_MIN : FIX_MAX;
        return neg ? -t_fix'({1'b0, m}) : t_fix'({1'b0, m});
    endfunction

    function automatic t_fix sat_add(input t_fix a, input t_fix b);
        t_fix s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) return a[63] ? FIX_MIN : FIX_MAX;
        return s;
    endfunction

    function automatic t_fix sat_sub(input t_fix a, input t_fix b);
        t_fix s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) return a[63] ? FIX_MIN : FIX_MAX;
        return s;
    endfunction

    // Shift right by n, rounding to nearest with ties away from zero.
    function automatic t_fix rnd_shr(input t_fix v, input int unsigned n);
        logic [64:0] m;
        logic [64:0] h;
        m = {1'b0, mag64(v)};
        if (n == 0) return v;
        h = 65'd1 << (n - 1);
        m = (m + h) >> n;
        return v[63] ? -t_fix'(m[63:0]) : t_fix'(m[63:0]);
    endfunction

endpackage

@@ hw/rtl/cpt_mul.sv @@
// ----------------------------------------------------------------------------
// cpt_mul
// Pipelined rounding multiplier lanes: round(a * b / 2^SH), saturated,
// built from 32 by 32 partial products over four register stages.
// ----------------------------------------------------------------------------
module cpt_mul
    import cpt_pkg::*;
#(
    parameter int LANES = 1,
    parameter int SH    = WORK_FRAC,
    parameter int SW    = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_fix          i_a [LANES],
    input  t_fix          i_b [LANES],
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output t_fix          o_p [LANES],
    output logic [SW-1:0] o_side
);

    localparam logic [127:0] RND = 128'(SH > 0) << (SH > 0 ? SH - 1 : 0);

    logic          r_v  [1:4];
    logic [SW-1:0] r_sd [1:4];

    logic          r_neg1 [LANES];
    logic [63:0]   r_ma   [LANES];
    logic [63:0]   r_mb   [LANES];
    logic          r_neg2 [LANES];
    logic [63:0]   r_pp   [LANES][4];
    logic          r_neg3 [LANES];
    logic [127:0]  r_m    [LANES];
    t_fix          r_p    [LANES];
    logic [127:0]  n_t    [LANES];

    // Valid bits and sideband travel with the lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 4; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[1] <= i_valid;
            for (int k = 2; k <= 4; k++) r_v[k] <= r_v[k-1];
        end
        if (i_en) begin
            r_sd[1] <= i_side;
            for (int k = 2; k <= 4; k++) r_sd[k] <= r_sd[k-1];
        end
    end

    // Rounding and saturation of the full product.
    always_comb begin
        for (int l = 0; l < LANES; l++) n_t[l] = (r_m[l] + RND) >> SH;
    end

    // Magnitudes, partial products, their sum, then the rounded result.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_neg1[l] <= i_a[l][63] ^ i_b[l][63];
                r_ma[l]   <= mag64(i_a[l]);
                r_mb[l]   <= mag64(i_b[l]);

                r_neg2[l]   <= r_neg1[l];
                r_pp[l][0]  <= r_ma[l][31:0]  * r_mb[l][31:0];
                r_pp[l][1]  <= r_ma[l][31:0]  * r_mb[l][63:32];
                r_pp[l][2]  <= r_ma[l][63:32] * r_mb[l][31:0];
                r_pp[l][3]  <= r_ma[l][63:32] * r_mb[l][63:32];

                r_neg3[l] <= r_neg2[l];
                r_m[l]    <= 128'(r_pp[l][0]) + (128'(r_pp[l][1]) << 32)
                           + (128'(r_pp[l][2]) << 32) + (128'(r_pp[l][3]) << 64);

                r_p[l] <= sat_pack(r_neg3[l], |n_t[l][127:63], n_t[l][62:0]);
            end
        end
    end

    assign o_valid = r_v[4];
    assign o_side  = r_sd[4];
    assign o_p     = r_p;

endmodule

@@ hw/rtl/cpt_div.sv @@
// ----------------------------------------------------------------------------
// cpt_div
// Pipelined restoring divider: round(a * 2^SH / b), saturated, with
// DIV_STEP quotient bits resolved per register stage.
// ----------------------------------------------------------------------------
module cpt_div
    import cpt_pkg::*;
#(
    parameter int SH = WORK_FRAC,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_fix          i_a,
    input  t_fix          i_b,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output t_fix          o_q,
    output logic [SW-1:0] o_side
);

    localparam int NB   = 64 + SH;
    localparam int NSTG = (NB + DIV_STEP - 1) / DIV_STEP;
    localparam int NP   = NSTG * DIV_STEP;

    // Partial remainder and the numerator word that the quotient shifts into.
    typedef struct packed {
        logic [63:0]   r;
        logic [NP-1:0] z;
    } t_dstate;

    typedef struct packed {
        logic neg;
        logic zero;
        logic aneg;
    } t_dflag;

    function automatic t_dstate div_iter(input t_dstate s, input logic [63:0] d);
        logic        carry;
        logic [63:0] rs;
        t_dstate     o;
        o = s;
        for (int k = 0; k < DIV_STEP; k++) begin
            carry = o.r[63];
            rs    = {o.r[62:0], o.z[NP-1]};
            o.z   = {o.z[NP-2:0], 1'b0};
            if (carry || rs >= d) begin
                rs     = rs - d;
                o.z[0] = 1'b1;
            end
            o.r = rs;
        end
        return o;
    endfunction

    logic          r_v  [0:NSTG];
    logic [SW-1:0] r_sd [0:NSTG];
    t_dstate       r_st [0:NSTG];
    logic [63:0]   r_d  [0:NSTG];
    t_dflag        r_fl [0:NSTG];

    logic          r_ov;
    logic [SW-1:0] r_osd;
    t_fix          r_q;

    logic          n_rnd;
    logic [NP:0]   n_qp;

    // Entry stage: magnitudes and the shifted numerator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else if (i_en) r_v[0] <= i_valid;
        if (i_en) begin
            r_sd[0]      <= i_side;
            r_st[0].r    <= '0;
            r_st[0].z    <= NP'(mag64(i_a)) << SH;
            r_d[0]       <= mag64(i_b);
            r_fl[0].neg  <= i_a[63] ^ i_b[63];
            r_fl[0].zero <= (i_b == '0);
            r_fl[0].aneg <= i_a[63];
        end
    end

    // Long-division stages.
    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k+1] <= 1'b0;
            else if (i_en) r_v[k+1] <= r_v[k];
            if (i_en) begin
                r_sd[k+1] <= r_sd[k];
                r_st[k+1] <= div_iter(r_st[k], r_d[k]);
                r_d[k+1]  <= r_d[k];
                r_fl[k+1] <= r_fl[k];
            end
        end
    end

    // Round half up on the remainder, then sign and saturate.
    always_comb begin
        n_rnd = r_st[NSTG].r >= (r_d[NSTG] - r_st[NSTG].r);
        n_qp  = {1'b0, r_st[NSTG].z} + (NP+1)'(n_rnd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (i_en) r_ov <= r_v[NSTG];
        if (i_en) begin
            r_osd <= r_sd[NSTG];
            if (r_fl[NSTG].zero) r_q <= r_fl[NSTG].aneg ? FIX_MIN : FIX_MAX;
            else r_q <= sat_pack(r_fl[NSTG].neg, |n_qp[NP:63], n_qp[62:0]);
        end
    end

    assign o_valid = r_ov;
    assign o_side  = r_osd;
    assign o_q     = r_q;

endmodule

@@ hw/rtl/camera_projection_texcoord.sv @@
// ----------------------------------------------------------------------------
// camera_projection_texcoord
// Projects world points through a calibrated pinhole camera with lens gain
// and returns pixel position and clamped texture coordinates.
// ----------------------------------------------------------------------------
// The block takes one world point per clock while o_in_ready is high and
// returns one result beat per point, in order. Most pipeline stages are in the
// three long-division pipelines (two bits per stage, 48 stages for the focal,
// pitch quotients and 32 for the texture quotients); the multipliers take four
// stages each. An output register with a skid stage lets the pipeline keep
// taking points while one result waits; a second one fills the skid stage and
// stalls the pipeline until taken. Load the coefficient words, width and height
// while no point is in flight; a coefficient word is stored at the index last
// written to the select register, and writes to an index above 22 are dropped.
module camera_projection_texcoord
    import cpt_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
    parameter int COEF_FRAC_BITS  = COEF_FRAC_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [COEF_W-1:0]    i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [31:0]   i_world_x,
    input  logic signed [31:0]   i_world_y,
    input  logic signed [31:0]   i_world_z,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [16:0]          o_tex_s,
    output logic [16:0]          o_tex_t,
    output logic signed [31:0]   o_pixel_col,
    output logic signed [31:0]   o_pixel_row,
    output logic                 o_depth_fault
);

    localparam int W_SH   = WORK_FRAC - COORD_FRAC_BITS;
    localparam int CF_R   = (COEF_FRAC_BITS >= WORK_FRAC) ? COEF_FRAC_BITS - WORK_FRAC : 0;
    localparam int CF_L   = (COEF_FRAC_BITS < WORK_FRAC) ? WORK_FRAC - COEF_FRAC_BITS : 0;
    localparam int TEX_SH = WORK_FRAC - TEX_FRAC;
    localparam logic [16:0] TEX_ONE = 17'(1 << TEX_FRAC);
    localparam t_fix PIX_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam t_fix PIX_MIN = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        t_fix c0;
        t_fix c1;
        logic fault;
    } t_sb;

    typedef struct packed {
        t_fix ys;
        logic fault;
    } t_sd;

    typedef struct packed {
        t_fix r2;
        t_fix scol;
        t_fix ys;
        logic fault;
    } t_sf;

    typedef struct packed {
        t_fix m0;
        t_fix cxx;
        t_fix cxyc;
        t_fix cxyr;
        t_fix cyy;
        t_fix scol;
        t_fix ys;
        logic fault;
    } t_sg;

    typedef struct packed {
        t_fix m1;
        t_sg  g;
    } t_sh;

    typedef struct packed {
        t_fix b;
        t_fix m1;
        t_fix m2;
        t_fix cxx;
        t_fix cxyc;
        t_fix cxyr;
        t_fix cyy;
        t_fix kc;
        t_fix kr;
        t_fix scol;
        t_fix ys;
        logic fault;
    } t_ist;

    typedef struct packed {
        t_fix col;
        t_fix row;
        logic fault;
    } t_sm;

    typedef struct packed {
        logic [16:0]        s;
        logic [16:0]        t;
        logic signed [31:0] pc;
        logic signed [31:0] pr;
        logic               fault;
    } t_res;

    // Calibration word to the working format.
    function automatic t_fix coef_conv(input logic [COEF_W-1:0] d);
        t_fix c;
        c = t_fix'($signed(d));
        if (COEF_FRAC_BITS >= WORK_FRAC) return rnd_shr(c, CF_R);
        return c <<< CF_L;
    endfunction

    function automatic logic [16:0] tex_clamp(input t_fix v);
        t_fix x;
        x = rnd_shr(v, TEX_SH);
        if (x[63]) return '0;
        if (x > t_fix'(TEX_ONE)) return TEX_ONE;
        return x[16:0];
    endfunction

    function automatic logic signed [31:0] pix_clamp(input t_fix v);
        t_fix x;
        x = rnd_shr(v, W_SH);
        if (x < PIX_MIN) return PIX_MIN[31:0];
        if (x > PIX_MAX) return PIX_MAX[31:0];
        return x[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers and coefficient store.
    // ------------------------------------------------------------------
    t_fix        r_coef [NUM_COEF];
    logic [4:0]  r_coef_sel;
    logic [13:0] r_width;
    logic [13:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEF; k++) r_coef[k] <= '0;
            r_coef_sel <= '0;
            r_width    <= 14'd640;
            r_height   <= 14'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_COEF_SEL:  r_coef_sel <= i_cfg_wdata[4:0];
                CFG_COEF_WORD: begin
                    if (r_coef_sel < 5'(NUM_COEF)) r_coef[r_coef_sel] <= coef_conv(i_cfg_wdata);
                end
                CFG_WIDTH:     r_width  <= i_cfg_wdata[13:0];
                CFG_HEIGHT:    r_height <= i_cfg_wdata[13:0];
                default: ;
            endcase
        end
    end

    // Texture divisors: size minus one, never below one.
    t_fix w_wd;
    t_fix w_hd;
    assign w_wd = t_fix'(64'(r_width  >= 14'd2 ? r_width  - 14'd1 : 14'd1));
    assign w_hd = t_fix'(64'(r_height >= 14'd2 ? r_height - 14'd1 : 14'd1));

    // ------------------------------------------------------------------
    // Pipeline advance and input handshake.
    // ------------------------------------------------------------------
    logic r_skid_v;
    logic en;
    assign en         = !r_skid_v;
    assign o_in_ready = en;

    t_fix w_w [3];
    assign w_w[0] = t_fix'(i_world_x) <<< W_SH;
    assign w_w[1] = t_fix'(i_world_y) <<< W_SH;
    assign w_w[2] = t_fix'(i_world_z) <<< W_SH;

    // Rotation products.
    t_fix a_a [9];
    t_fix a_b [9];
    t_fix a_p [9];
    logic a_v;
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            a_a[k] = r_coef[K_ROT + k];
            a_b[k] = w_w[k % 3];
        end
    end

    cpt_mul #(.LANES(9), .SH(WORK_FRAC), .SW(1)) u_rot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_in_valid),
        .i_a(a_a), .i_b(a_b), .i_side(1'b0),
        .o_valid(a_v), .o_p(a_p), .o_side()
    );

    // Translation plus the three row terms, one saturating add per stage.
    logic r_a1_v, r_a2_v, r_a3_v;
    t_fix r_a1_c [3];
    t_fix r_a1_p1 [3];
    t_fix r_a1_p2 [3];
    t_fix r_a2_c [3];
    t_fix r_a2_p2 [3];
    t_fix r_a3_c [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1_v <= 1'b0;
            r_a2_v <= 1'b0;
            r_a3_v <= 1'b0;
        end else if (en) begin
            r_a1_v <= a_v;
            r_a2_v <= r_a1_v;
            r_a3_v <= r_a2_v;
        end
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r_a1_c[j]  <= sat_add(r_coef[K_TRN + j], a_p[3*j]);
                r_a1_p1[j] <= a_p[3*j + 1];
                r_a1_p2[j] <= a_p[3*j + 2];
                r_a2_c[j]  <= sat_add(r_a1_c[j], r_a1_p1[j]);
                r_a2_p2[j] <= r_a1_p2[j];
                r_a3_c[j]  <= sat_add(r_a2_c[j], r_a2_p2[j]);
            end
        end
    end

    // Projection factor f / depth; zero depth is flagged here.
    t_sb  b_si, b_so;
    t_fix b_g;
    logic b_v;
    assign b_si = '{c0: r_a3_c[0], c1: r_a3_c[1], fault: (r_a3_c[2] == '0)};

    cpt_div #(.SH(WORK_FRAC), .SW($bits(t_sb))) u_gain (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_a3_v),
        .i_a(r_coef[K_F]), .i_b(r_a3_c[2]), .i_side(b_si),
        .o_valid(b_v), .o_q(b_g), .o_side(b_so)
    );

    // Normalized image-plane coordinates.
    t_fix c_a [2];
    t_fix c_b [2];
    t_fix c_p [2];
    logic c_v, c_fault;
    assign c_a[0] = b_so.c0;
    assign c_a[1] = b_so.c1;
    assign c_b[0] = b_g;
    assign c_b[1] = b_g;

    cpt_mul #(.LANES(2), .SH(WORK_FRAC), .SW(1)) u_proj (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(b_v),
        .i_a(c_a), .i_b(c_b), .i_side(b_so.fault),
        .o_valid(c_v), .o_p(c_p), .o_side(c_fault)
    );

    // Squares, the scaled column, and the doubled cross terms.
    t_fix d1_a [3];
    t_fix d1_b [3];
    t_fix d1_p [3];
    t_fix d2_a [3];
    t_fix d2_b [3];
    t_fix d2_p [3];
    t_sd  d_si, d_so;
    logic d_v;
    assign d1_a[0] = c_p[0];
    assign d1_b[0] = c_p[0];
    assign d1_a[1] = c_p[1];
    assign d1_b[1] = c_p[1];
    assign d1_a[2] = r_coef[K_SX];
    assign d1_b[2] = c_p[0];
    assign d2_a[0] = c_p[0];
    assign d2_b[0] = c_p[0];
    assign d2_a[1] = c_p[1];
    assign d2_b[1] = c_p[1];
    assign d2_a[2] = c_p[0];
    assign d2_b[2] = c_p[1];
    assign d_si    = '{ys: c_p[1], fault: c_fault};

    cpt_mul #(.LANES(3), .SH(WORK_FRAC), .SW($bits(t_sd))) u_sq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(c_v),
        .i_a(d1_a), .i_b(d1_b), .i_side(d_si),
        .o_valid(d_v), .o_p(d1_p), .o_side(d_so)
    );

    cpt_mul #(.LANES(3), .SH(WORK_FRAC - 1), .SW(1)) u_sq2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(c_v),
        .i_a(d2_a), .i_b(d2_b), .i_side(1'b0),
        .o_valid(), .o_p(d2_p), .o_side()
    );

    // Radius squared, then the two cross sums.
    logic r_e1_v, r_e2_v;
    t_fix r_e1_r2, r_e1_xsh, r_e1_ysh, r_e1_xyh, r_e1_scol, r_e1_ys;
    logic r_e1_fault;
    t_fix r_e2_r2, r_e2_xx, r_e2_yy, r_e2_xyh, r_e2_scol, r_e2_ys;
    logic r_e2_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
        end else if (en) begin
            r_e1_v <= d_v;
            r_e2_v <= r_e1_v;
        end
        if (en) begin
            r_e1_r2    <= sat_add(d1_p[0], d1_p[1]);
            r_e1_xsh   <= d2_p[0];
            r_e1_ysh   <= d2_p[1];
            r_e1_xyh   <= d2_p[2];
            r_e1_scol  <= d1_p[2];
            r_e1_ys    <= d_so.ys;
            r_e1_fault <= d_so.fault;
            r_e2_r2    <= r_e1_r2;
            r_e2_xx    <= sat_add(r_e1_r2, r_e1_xsh);
            r_e2_yy    <= sat_add(r_e1_r2, r_e1_ysh);
            r_e2_xyh   <= r_e1_xyh;
            r_e2_scol  <= r_e1_scol;
            r_e2_ys    <= r_e1_ys;
            r_e2_fault <= r_e1_fault;
        end
    end

    // r4, the k0 term and the four cross terms.
    t_fix f_a [6];
    t_fix f_b [6];
    t_fix f_p [6];
    t_sf  f_si, f_so;
    logic f_v;
    assign f_a[0] = r_e2_r2;
    assign f_b[0] = r_e2_r2;
    assign f_a[1] = r_coef[K_K0];
    assign f_b[1] = r_e2_r2;
    assign f_a[2] = r_coef[K_K3];
    assign f_b[2] = r_e2_xx;
    assign f_a[3] = r_coef[K_K4];
    assign f_b[3] = r_e2_xyh;
    assign f_a[4] = r_coef[K_K3];
    assign f_b[4] = r_e2_xyh;
    assign f_a[5] = r_coef[K_K4];
    assign f_b[5] = r_e2_yy;
    assign f_si   = '{r2: r_e2_r2, scol: r_e2_scol, ys: r_e2_ys, fault: r_e2_fault};

    cpt_mul #(.LANES(6), .SH(WORK_FRAC), .SW($bits(t_sf))) u_dist1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_e2_v),
        .i_a(f_a), .i_b(f_b), .i_side(f_si),
        .o_valid(f_v), .o_p(f_p), .o_side(f_so)
    );

    // r6 and the k1 term.
    t_fix g_a [2];
    t_fix g_b [2];
    t_fix g_p [2];
    t_sg  g_si, g_so;
    logic g_v;
    assign g_a[0] = f_p[0];
    assign g_b[0] = f_so.r2;
    assign g_a[1] = r_coef[K_K1];
    assign g_b[1] = f_p[0];
    assign g_si   = '{m0: f_p[1], cxx: f_p[2], cxyc: f_p[3], cxyr: f_p[4], cyy: f_p[5],
                      scol: f_so.scol, ys: f_so.ys, fault: f_so.fault};

    cpt_mul #(.LANES(2), .SH(WORK_FRAC), .SW($bits(t_sg))) u_dist2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(f_v),
        .i_a(g_a), .i_b(g_b), .i_side(g_si),
        .o_valid(g_v), .o_p(g_p), .o_side(g_so)
    );

    // The k2 term.
    t_fix h_a [1];
    t_fix h_b [1];
    t_fix h_p [1];
    t_sh  h_si, h_so;
    logic h_v;
    assign h_a[0] = r_coef[K_K2];
    assign h_b[0] = g_p[0];
    assign h_si   = '{m1: g_p[1], g: g_so};

    cpt_mul #(.LANES(1), .SH(WORK_FRAC), .SW($bits(t_sh))) u_dist3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(g_v),
        .i_a(h_a), .i_b(h_b), .i_side(h_si),
        .o_valid(h_v), .o_p(h_p), .o_side(h_so)
    );

    // Lens gain sums, one saturating add per lane and stage, in model order.
    t_ist r_i   [5];
    logic r_i_v [5];
    t_ist n_i   [5];

    always_comb begin
        n_i[0]      = '0;
        n_i[0].b    = sat_add(FIX_ONE, h_so.g.m0);
        n_i[0].m1   = h_so.m1;
        n_i[0].m2   = h_p[0];
        n_i[0].cxx  = h_so.g.cxx;
        n_i[0].cxyc = h_so.g.cxyc;
        n_i[0].cxyr = h_so.g.cxyr;
        n_i[0].cyy  = h_so.g.cyy;
        n_i[0].scol = h_so.g.scol;
        n_i[0].ys   = h_so.g.ys;
        n_i[0].fault = h_so.g.fault;

        n_i[1]    = r_i[0];
        n_i[1].b  = sat_add(r_i[0].b, r_i[0].m1);
        n_i[2]    = r_i[1];
        n_i[2].b  = sat_add(r_i[1].b, r_i[1].m2);
        n_i[3]    = r_i[2];
        n_i[3].kc = sat_add(r_i[2].b, r_i[2].cxx);
        n_i[3].kr = sat_add(r_i[2].b, r_i[2].cxyr);
        n_i[4]    = r_i[3];
        n_i[4].kc = sat_add(r_i[3].kc, r_i[3].cxyc);
        n_i[4].kr = sat_add(r_i[3].kr, r_i[3].cyy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) r_i_v[k] <= 1'b0;
        end else if (en) begin
            r_i_v[0] <= h_v;
            for (int k = 1; k < 5; k++) r_i_v[k] <= r_i_v[k-1];
        end
        if (en) begin
            for (int k = 0; k < 5; k++) r_i[k] <= n_i[k];
        end
    end

    // Distorted column and row before the pitch division.
    t_fix j_a [2];
    t_fix j_b [2];
    t_fix j_p [2];
    logic j_v, j_fault;
    assign j_a[0] = r_i[4].scol;
    assign j_b[0] = r_i[4].kc;
    assign j_a[1] = r_i[4].ys;
    assign j_b[1] = r_i[4].kr;

    cpt_mul #(.LANES(2), .SH(WORK_FRAC), .SW(1)) u_gain_apply (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_i_v[4]),
        .i_a(j_a), .i_b(j_b), .i_side(r_i[4].fault),
        .o_valid(j_v), .o_p(j_p), .o_side(j_fault)
    );

    // Division by the pixel pitch.
    t_fix k_col, k_row;
    logic k_v, k_fault;

    cpt_div #(.SH(WORK_FRAC), .SW(1)) u_pitch_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(j_v),
        .i_a(j_p[0]), .i_b(r_coef[K_DX]), .i_side(j_fault),
        .o_valid(k_v), .o_q(k_col), .o_side(k_fault)
    );

    cpt_div #(.SH(WORK_FRAC), .SW(1)) u_pitch_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(j_v),
        .i_a(j_p[1]), .i_b(r_coef[K_DY]), .i_side(1'b0),
        .o_valid(), .o_q(k_row), .o_side()
    );

    // Offset by the image centre.
    logic r_l_v, r_l_fault;
    t_fix r_l_col, r_l_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_l_v <= 1'b0;
        else if (en) r_l_v <= k_v;
        if (en) begin
            r_l_col   <= sat_add(r_coef[K_XC], k_col);
            r_l_row   <= sat_add(r_coef[K_YC], k_row);
            r_l_fault <= k_fault;
        end
    end

    // Normalization by the texture size.
    t_sm  m_si, m_so;
    t_fix m_s, m_t;
    logic m_v;
    assign m_si = '{col: r_l_col, row: r_l_row, fault: r_l_fault};

    cpt_div #(.SH(0), .SW($bits(t_sm))) u_norm_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_l_v),
        .i_a(r_l_col), .i_b(w_wd), .i_side(m_si),
        .o_valid(m_v), .o_q(m_s), .o_side(m_so)
    );

    cpt_div #(.SH(0), .SW(1)) u_norm_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_l_v),
        .i_a(r_l_row), .i_b(w_hd), .i_side(1'b0),
        .o_valid(), .o_q(m_t), .o_side()
    );

    // Flip t, then round and clamp everything into the result.
    logic r_n_v, r_n_fault, r_f_v;
    t_fix r_n_s, r_n_t, r_n_col, r_n_row;
    t_res r_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
            r_f_v <= 1'b0;
        end else if (en) begin
            r_n_v <= m_v;
            r_f_v <= r_n_v;
        end
        if (en) begin
            r_n_s     <= m_s;
            r_n_t     <= sat_sub(FIX_ONE, m_t);
            r_n_col   <= m_so.col;
            r_n_row   <= m_so.row;
            r_n_fault <= m_so.fault;
            if (r_n_fault) begin
                r_f <= '{s: TEX_ONE, t: '0, pc: PIX_MAX[31:0], pr: PIX_MAX[31:0],
                         fault: 1'b1};
            end else begin
                r_f <= '{s: tex_clamp(r_n_s), t: tex_clamp(r_n_t),
                         pc: pix_clamp(r_n_col), pr: pix_clamp(r_n_row), fault: 1'b0};
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage.
    // ------------------------------------------------------------------
    logic r_out_v;
    t_res r_out;
    t_res r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_out_ready) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (r_f_v) begin
            if (!r_out_v || i_out_ready) begin
                r_out   <= r_f;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= r_f;
                r_skid_v <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_tex_s       = r_out.s;
    assign o_tex_t       = r_out.t;
    assign o_pixel_col   = r_out.pc;
    assign o_pixel_row   = r_out.pr;
    assign o_depth_fault = r_out.fault;

endmodule

@@ tb/sv/tb_camera_projection_texcoord.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_camera_projection_texcoord
// Self-checking bench for the camera projection block. World points are
// streamed through a valid/ready driver with random gaps. A bit-exact fixed
// point model predicts each result when its point is accepted. A monitor with
// random stalls compares every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_camera_projection_texcoord;
    import cpt_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 250;

    typedef logic [127:0] t_wide;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_point;

    typedef struct packed {
        logic [16:0] s;
        logic [16:0] t;
        logic [31:0] col;
        logic [31:0] row;
        logic        fault;
    } t_tex_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = CFG_COEF_SEL;
    logic [COEF_W-1:0]    i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic signed [31:0]   i_world_x = '0;
    logic signed [31:0]   i_world_y = '0;
    logic signed [31:0]   i_world_z = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [16:0]          o_tex_s;
    logic [16:0]          o_tex_t;
    logic signed [31:0]   o_pixel_col;
    logic signed [31:0]   o_pixel_row;
    logic                 o_depth_fault;

    camera_projection_texcoord u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_world_x    (i_world_x),
        .i_world_y    (i_world_y),
        .i_world_z    (i_world_z),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_tex_s      (o_tex_s),
        .o_tex_t      (o_tex_t),
        .o_pixel_col  (o_pixel_col),
        .o_pixel_row  (o_pixel_row),
        .o_depth_fault(o_depth_fault)
    );

    // Model copy of the calibration registers.
    logic [COEF_W-1:0] cal_words [NUM_COEF];
    logic [4:0]        cal_sel;
    logic [13:0]       tex_width;
    logic [13:0]       tex_height;

    t_point      point_queue [$];
    t_tex_result tex_expected [$];
    int          error_count = 0;
    bit          no_gaps = 1'b0;

    // ------------------------------------------------------------------
    // Fixed point helpers: 64-bit saturating words, 32 fraction bits.
    // ------------------------------------------------------------------
    function automatic t_wide abs_wide(input t_fix v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        return t_wide'(m);
    endfunction

    function automatic t_fix signed_sat(input logic neg, input t_wide m);
        if (m >= (t_wide'(1) << 63)) return neg ? FIX_MIN : FIX_MAX;
        return neg ? -t_fix'(m[63:0]) : t_fix'(m[63:0]);
    endfunction

    function automatic t_fix fx_mul(input t_fix a, input t_fix b, input int sh);
        t_wide m;
        m = abs_wide(a) * abs_wide(b);
        if (sh > 0) m = (m + (t_wide'(1) << (sh - 1))) >> sh;
        return signed_sat(a[63] ^ b[63], m);
    endfunction

    // Quotient rounded to nearest, saturating on a zero divisor.
    function automatic t_fix fx_div(input t_fix a, input t_fix b, input int sh);
        t_wide n;
        t_wide d;
        t_wide q;
        t_wide r;
        if (b == 0) return a[63] ? FIX_MIN : FIX_MAX;
        n = abs_wide(a) << sh;
        d = abs_wide(b);
        q = n / d;
        r = n % d;
        if (r >= d - r) q = q + 1;
        return signed_sat(a[63] ^ b[63], q);
    endfunction

    function automatic t_fix fx_add(input t_fix a, input t_fix b);
        t_fix s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) return a[63] ? FIX_MIN : FIX_MAX;
        return s;
    endfunction

    function automatic t_fix fx_sub(input t_fix a, input t_fix b);
        t_fix s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) return a[63] ? FIX_MIN : FIX_MAX;
        return s;
    endfunction

    function automatic t_fix fx_clamp(input t_fix v, input t_fix lo, input t_fix hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_fix cal_value(input int k);
        return t_fix'({{16{cal_words[k][47]}}, cal_words[k]});
    endfunction

    // Project one world point to pixel and texture coordinates.
    function automatic t_tex_result project_point(input t_point p);
        t_fix        w [3];
        t_fix        cam [3];
        t_fix        acc, g, xs, ys, r2, r4, r6, xx, yy, xy, base, kc, kr;
        t_fix        col, row, s, t, pc, pr, wd, hd;
        t_tex_result res;
        w[0] = t_fix'({{32{p.x[31]}}, p.x}) <<< (WORK_FRAC - COORD_FRAC_DEF);
        w[1] = t_fix'({{32{p.y[31]}}, p.y}) <<< (WORK_FRAC - COORD_FRAC_DEF);
        w[2] = t_fix'({{32{p.z[31]}}, p.z}) <<< (WORK_FRAC - COORD_FRAC_DEF);
        for (int j = 0; j < 3; j++) begin
            acc = cal_value(K_TRN + j);
            for (int i = 0; i < 3; i++)
                acc = fx_add(acc, fx_mul(cal_value(K_ROT + 3 * j + i), w[i], WORK_FRAC));
            cam[j] = acc;
        end
        // Point on the camera plane: saturated outputs and the fault flag.
        if (cam[2] == 0) begin
            res.s = 17'd65536;
            res.t = '0;
            res.col = 32'h7FFF_FFFF;
            res.row = 32'h7FFF_FFFF;
            res.fault = 1'b1;
            return res;
        end
        g  = fx_div(cal_value(K_F), cam[2], WORK_FRAC);
        xs = fx_mul(cam[0], g, WORK_FRAC);
        ys = fx_mul(cam[1], g, WORK_FRAC);

        // Radial and cross terms of the lens gain.
        r2 = fx_add(fx_mul(xs, xs, WORK_FRAC), fx_mul(ys, ys, WORK_FRAC));
        r4 = fx_mul(r2, r2, WORK_FRAC);
        r6 = fx_mul(r4, r2, WORK_FRAC);
        xx = fx_add(r2, fx_mul(xs, xs, WORK_FRAC - 1));
        yy = fx_add(r2, fx_mul(ys, ys, WORK_FRAC - 1));
        xy = fx_mul(xs, ys, WORK_FRAC - 1);
        base = fx_add(FIX_ONE, fx_mul(cal_value(K_K0), r2, WORK_FRAC));
        base = fx_add(base, fx_mul(cal_value(K_K1), r4, WORK_FRAC));
        base = fx_add(base, fx_mul(cal_value(K_K2), r6, WORK_FRAC));
        kc = fx_add(fx_add(base, fx_mul(cal_value(K_K3), xx, WORK_FRAC)),
                    fx_mul(cal_value(K_K4), xy, WORK_FRAC));
        kr = fx_add(fx_add(base, fx_mul(cal_value(K_K3), xy, WORK_FRAC)),
                    fx_mul(cal_value(K_K4), yy, WORK_FRAC));

        // Pixel position about the image centre.
        col = fx_mul(fx_mul(cal_value(K_SX), xs, WORK_FRAC), kc, WORK_FRAC);
        col = fx_add(cal_value(K_XC), fx_div(col, cal_value(K_DX), WORK_FRAC));
        row = fx_add(cal_value(K_YC),
                     fx_div(fx_mul(ys, kr, WORK_FRAC), cal_value(K_DY), WORK_FRAC));

        // Texture coordinates, t flipped, both clamped to the unit range.
        wd = tex_width >= 2 ? t_fix'(tex_width) - 1 : t_fix'(1);
        hd = tex_height >= 2 ? t_fix'(tex_height) - 1 : t_fix'(1);
        s = fx_div(col, wd, 0);
        t = fx_sub(FIX_ONE, fx_div(row, hd, 0));
        s = fx_clamp(fx_mul(s, 1, WORK_FRAC - TEX_FRAC), 0, t_fix'(1) <<< TEX_FRAC);
        t = fx_clamp(fx_mul(t, 1, WORK_FRAC - TEX_FRAC), 0, t_fix'(1) <<< TEX_FRAC);
        pc = fx_clamp(fx_mul(col, 1, WORK_FRAC - COORD_FRAC_DEF),
                      -(t_fix'(1) <<< 31), (t_fix'(1) <<< 31) - 1);
        pr = fx_clamp(fx_mul(row, 1, WORK_FRAC - COORD_FRAC_DEF),
                      -(t_fix'(1) <<< 31), (t_fix'(1) <<< 31) - 1);
        res.s = s[16:0];
        res.t = t[16:0];
        res.col = pc[31:0];
        res.row = pr[31:0];
        res.fault = 1'b0;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Point driver: one beat per queued point, random gaps between beats.
    // ------------------------------------------------------------------
    int in_gap = 0;

    always @(posedge i_clk) begin
        logic   next_valid;
        t_point p;
        next_valid = 1'b0;
        if (!i_rst_n) begin
            in_gap = 0;
        end else if (i_in_valid && !o_in_ready) begin
            next_valid = 1'b1;
        end else begin
            if (i_in_valid) begin
                p.x = i_world_x;
                p.y = i_world_y;
                p.z = i_world_z;
                tex_expected.push_back(project_point(p));
            end
            if (in_gap > 0) begin
                in_gap--;
            end else if (point_queue.size() > 0) begin
                p = point_queue.pop_front();
                i_world_x <= p.x;
                i_world_y <= p.y;
                i_world_z <= p.z;
                next_valid = 1'b1;
                in_gap = no_gaps ? 0 : $urandom_range(0, 5);
            end
        end
        i_in_valid <= next_valid;
    end

    // ------------------------------------------------------------------
    // Result monitor: random stalls, field-by-field compare.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        $display("ERROR t=%0t %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
        error_count++;
    endtask

    int out_stall = 0;

    always @(posedge i_clk) begin
        t_tex_result want;
        if (!i_rst_n) begin
            out_stall = 0;
        end else if (o_out_valid && i_out_ready) begin
            if (tex_expected.size() == 0) begin
                report_mismatch("unexpected beat", o_pixel_col, 0);
            end else begin
                want = tex_expected.pop_front();
                if (o_tex_s !== want.s) report_mismatch("tex_s", o_tex_s, want.s);
                if (o_tex_t !== want.t) report_mismatch("tex_t", o_tex_t, want.t);
                if (o_pixel_col !== want.col)
                    report_mismatch("pixel_col", o_pixel_col, want.col);
                if (o_pixel_row !== want.row)
                    report_mismatch("pixel_row", o_pixel_row, want.row);
                if (o_depth_fault !== want.fault)
                    report_mismatch("depth_fault", o_depth_fault, want.fault);
            end
            out_stall = no_gaps ? 0 : $urandom_range(0, 5);
        end else if (out_stall > 0) begin
            out_stall--;
        end
        i_out_ready <= i_rst_n && out_stall == 0;
    end

    // ------------------------------------------------------------------
    // Watchdog on cycles with no beat on either channel.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else if (++idle_cycles >= IDLE_LIMIT) begin
            $display("camera_projection_texcoord: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    task automatic cfg_write(input t_cfg_idx idx, input logic [COEF_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_COEF_SEL:  cal_sel = data[4:0];
            CFG_COEF_WORD: if (cal_sel < NUM_COEF) cal_words[cal_sel] = data;
            CFG_WIDTH:     tex_width = data[13:0];
            CFG_HEIGHT:    tex_height = data[13:0];
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_coef(input int k, input logic [COEF_W-1:0] v);
        cfg_write(CFG_COEF_SEL, COEF_W'(k));
        cfg_write(CFG_COEF_WORD, v);
    endtask

    // Random value in thousandths, converted to Q16.32 with random low bits.
    function automatic logic [COEF_W-1:0] milli_coef(input int lo, input int hi);
        longint v;
        v = longint'($urandom_range(0, hi - lo)) + lo;
        return COEF_W'(v * 64'sd4294967 + $urandom_range(0, 4095));
    endfunction

    function automatic logic [COEF_W-1:0] units(input int u);
        return COEF_W'(longint'(u) <<< 32);
    endfunction

    // A plausible camera: near-identity rotation, depth offset, mild lens.
    task automatic load_camera();
        for (int k = 0; k < 9; k++)
            load_coef(K_ROT + k, (k % 4 == 0) ? milli_coef(900, 1100)
                                              : milli_coef(-150, 150));
        load_coef(K_TRN, milli_coef(-2000, 2000));
        load_coef(K_TRN + 1, milli_coef(-2000, 2000));
        load_coef(K_TRN + 2, milli_coef(2000, 30000));
        for (int k = K_K0; k <= K_K4; k++) load_coef(k, milli_coef(-200, 200));
        load_coef(K_F, milli_coef(300, 4000));
        load_coef(K_SX, milli_coef(800, 1200));
        load_coef(K_XC, milli_coef(0, 2000000));
        load_coef(K_YC, milli_coef(0, 2000000));
        load_coef(K_DX, milli_coef(1, 20));
        load_coef(K_DY, milli_coef(1, 20));
        // Writes past the last coefficient must be dropped.
        cfg_write(CFG_COEF_SEL, COEF_W'($urandom_range(NUM_COEF, 31)));
        cfg_write(CFG_COEF_WORD, COEF_W'({$urandom(), $urandom()}));
    endtask

    task automatic load_wild_camera();
        for (int k = 0; k < NUM_COEF; k++)
            load_coef(k, ($urandom_range(0, 1) == 0) ? COEF_W'({$urandom(), $urandom()})
                                                     : milli_coef(-3000, 3000));
    endtask

    task automatic set_image(input int w, input int h);
        cfg_write(CFG_WIDTH, COEF_W'({$urandom(), $urandom()} & ~48'h3FFF | COEF_W'(w)));
        cfg_write(CFG_HEIGHT, COEF_W'(h));
    endtask

    function automatic logic [31:0] fx16(input int u);
        return 32'(u <<< 16) + 32'($urandom_range(0, 65535));
    endfunction

    task automatic queue_point(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
        point_queue.push_back('{x: x, y: y, z: z});
    endtask

    // Mostly points in front of the camera, some raw noise.
    task automatic queue_random(input int n);
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                queue_point($urandom(), $urandom(), $urandom());
            else if (sel == 1)
                queue_point(fx16($urandom_range(0, 4000) - 2000),
                            fx16($urandom_range(0, 4000) - 2000),
                            fx16($urandom_range(0, 40) - 20));
            else
                queue_point(fx16($urandom_range(0, 20) - 10),
                            fx16($urandom_range(0, 20) - 10),
                            fx16($urandom_range(0, 40)));
        end
    endtask

    // Let the queued points drain and every result come back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (point_queue.size() != 0 || i_in_valid || tex_expected.size() != 0);
    endtask

    initial begin
        for (int k = 0; k < NUM_COEF; k++) cal_words[k] = '0;
        cal_sel = '0;
        tex_width = 14'd640;
        tex_height = 14'd480;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All coefficients zero after reset: every point lands at zero depth.
        queue_point(32'h0, 32'h0, 32'h0);
        queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_drained();

        // Identity camera ten units back, unit focal, 0.01 pitch.
        for (int k = 0; k < 3; k++) load_coef(K_ROT + 4 * k, units(1));
        load_coef(K_TRN + 2, units(10));
        load_coef(K_F, units(1));
        load_coef(K_SX, units(1));
        load_coef(K_XC, units(320));
        load_coef(K_YC, units(240));
        load_coef(K_DX, COEF_W'(64'd42949673));
        load_coef(K_DY, COEF_W'(64'd42949673));
        cfg_done();
        queue_point(32'h0, 32'h0, 32'h0);
        queue_point(fx16(1), fx16(-1), fx16(5));
        queue_point(fx16(3), fx16(2), 32'hFFF6_0000);          // zero depth
        queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        queue_point(fx16(-9), fx16(9), fx16(-9));              // just in front
        wait_drained();

        // Zero pitch saturates the quotient; tiny and huge image sizes.
        load_coef(K_K0, milli_coef(-200, 200));
        load_coef(K_K3, milli_coef(-200, 200));
        load_coef(K_DX, '0);
        load_coef(K_DY, '0);
        set_image(1, 0);
        cfg_done();
        queue_point(fx16(2), fx16(-2), fx16(1));
        queue_point(fx16(-2), fx16(2), fx16(1));
        queue_point(32'h0, 32'h0, fx16(3));
        wait_drained();
        load_coef(K_DX, COEF_W'(64'd42949673));
        load_coef(K_DY, milli_coef(1, 5));
        set_image(16383, 2);
        cfg_done();
        queue_point(fx16(4), fx16(4), fx16(2));
        queue_point(fx16(-4), fx16(-4), fx16(2));
        queue_point(fx16(0), fx16(-1), fx16(20));
        wait_drained();

        // Random cameras, image sizes from the extremes and typical values.
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 4) load_wild_camera();
            else load_camera();
            case (ph % 5)
                0: set_image(2, 8192);
                1: set_image(8192, 2);
                2: set_image($urandom_range(0, 16383), $urandom_range(0, 16383));
                default: set_image($urandom_range(2, 2000), $urandom_range(2, 2000));
            endcase
            cfg_done();
            no_gaps = (ph % 3 == 1);
            queue_random(115);
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("camera_projection_texcoord: match");
        end else begin
            $display("camera_projection_texcoord: mismatch");
        end
        $finish;
    end

endmodule
